FILE: hw/rtl/uda_pkg.sv
// Shared types and constants for the binary to decimal ASCII converter.
// No dependencies; imported by unsigned_to_decimal_ascii.
package uda_pkg;

	// Largest number of decimal digits a 64-bit value can need.
	localparam int unsigned MAX_DIGITS = 20;
	localparam int unsigned BCD_BITS   = 4 * MAX_DIGITS;
	localparam int unsigned CNT_BITS   = 5;
	localparam int unsigned CHAR_BITS  = 6;

	// ASCII code of '0', trimmed to the character field width.
	localparam logic [CHAR_BITS-1:0] ASCII_ZERO = 6'd48;

	// Sequencer states, one-hot.
	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_CONV = 4'b0010,
		ST_SKIP = 4'b0100,
		ST_SEND = 4'b1000
	} state_t;

	// One double-dabble correction: add three to every digit of five or more.
	function automatic logic [BCD_BITS-1:0] bcd_adjust(input logic [BCD_BITS-1:0] bcd);
		logic [BCD_BITS-1:0] res;
		res = bcd;
		for (int i = 0; i < MAX_DIGITS; i++) begin
			if (bcd[4*i +: 4] >= 4'd5) begin
				res[4*i +: 4] = bcd[4*i +: 4] + 4'd3;
			end
		end
		return res;
	endfunction

endpackage

FILE: hw/rtl/unsigned_to_decimal_ascii.sv
// Top level of the binary to decimal ASCII converter.
// Depends on uda_pkg for the state type, digit constants and the BCD correction.
//
//  channel   dir   payload (low bit first)                          end of run
//  s_*       in    tdata[63:0]  value                               -
//  m_*       out   tdata[5:0] digit_char, tdata[10:6] digit_total   tlast = last
//
// An item is taken while idle and converted bit by bit with shift-and-add-3; then
// its leading zero digits are dropped one at a time (up to 19) before the digit
// count is loaded, and the digits are sent one per cycle while m_tready is high.
// The shared BCD shift/correct unit also shifts the digits out one at a time.
// Reset clears the sequencer only; the datapath registers are loaded per item.
// A stalled m_tready holds the current digit; s_tready is high only when idle.
module unsigned_to_decimal_ascii #(
	parameter int unsigned VALUE_BITS = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [63:0] s_tdata,   // [63:0] value
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // [5:0] digit_char, [10:6] digit_total, [15:11] zero
	output logic        m_tlast
);
	import uda_pkg::*;

	localparam int unsigned BC_BITS = $clog2(VALUE_BITS + 1);

	state_t                state_q;
	logic [VALUE_BITS-1:0] val_q;
	logic [BC_BITS-1:0]    bit_cnt_q;
	logic [BCD_BITS-1:0]   bcd_q;
	logic [CNT_BITS-1:0]   total_q;
	logic [CNT_BITS-1:0]   rem_q;
	logic [BCD_BITS-1:0]   bcd_adj;
	logic [3:0]            top_digit;
	logic                  in_fire;
	logic                  out_fire;

	assign in_fire   = s_tvalid && s_tready;
	assign out_fire  = m_tvalid && m_tready;
	assign bcd_adj   = bcd_adjust(bcd_q);
	assign top_digit = bcd_q[BCD_BITS-1 -: 4];

	// Handshake and payload come straight from the held registers.
	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = (state_q == ST_SEND);
	assign m_tlast  = (rem_q == CNT_BITS'(1));
	assign m_tdata  = {5'd0, total_q, ASCII_ZERO + {2'b00, top_digit}};

	// Sequencer: convert bit by bit, drop leading zeros, then send digits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_fire) state_q <= ST_CONV;
				end
				ST_CONV: begin
					if (bit_cnt_q == BC_BITS'(1)) state_q <= ST_SKIP;
				end
				ST_SKIP: begin
					if (top_digit != 4'd0 || total_q == CNT_BITS'(1)) state_q <= ST_SEND;
				end
				ST_SEND: begin
					if (out_fire && m_tlast) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Datapath: the BCD register is the one shared shift/correct unit.
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				val_q     <= s_tdata[VALUE_BITS-1:0];
				bit_cnt_q <= BC_BITS'(VALUE_BITS);
				bcd_q     <= '0;
				total_q   <= CNT_BITS'(MAX_DIGITS);
			end
			ST_CONV: begin
				bcd_q     <= {bcd_adj[BCD_BITS-2:0], val_q[VALUE_BITS-1]};
				val_q     <= val_q << 1;
				bit_cnt_q <= bit_cnt_q - BC_BITS'(1);
			end
			ST_SKIP: begin
				if (top_digit == 4'd0 && total_q != CNT_BITS'(1)) begin
					bcd_q   <= bcd_q << 4;
					total_q <= total_q - CNT_BITS'(1);
				end else begin
					rem_q <= total_q;
				end
			end
			ST_SEND: begin
				if (out_fire) begin
					bcd_q <= bcd_q << 4;
					rem_q <= rem_q - CNT_BITS'(1);
				end
			end
			default: begin
				bcd_q <= bcd_q;
			end
		endcase
	end

	// The input side is never open while a result is being offered.
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(s_tready && m_tvalid))
		else $error("input open while digits are pending");

	// Digits sent are always decimal and the remaining count stays within the total.
	a_digit_ok: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (top_digit <= 4'd9 && rem_q != '0 && rem_q <= total_q))
		else $error("bad digit or digit count");

	// The last digit taken returns the block to idle.
	a_end_run: assert property (@(posedge clk) disable iff (!arst_n)
		(out_fire && m_tlast) |=> s_tready)
		else $error("block did not return to idle after last digit");

	// An accepted item always starts a conversion.
	a_start: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire |=> (state_q == ST_CONV && bcd_q == '0))
		else $error("conversion did not start");

endmodule
